// ===== src/mi3_pkg.sv =====
`timescale 1ns / 1ps

package mi3_pkg;

  // Entry format
  localparam int unsigned DataW  = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned NumEnt = 9;
  localparam int unsigned ThrW   = 31;

  // Intermediate widths, all exact
  localparam int unsigned ProdW    = 2 * DataW;          // aXY * aZW
  localparam int unsigned CofW     = 2 * DataW + 1;      // signed cofactor
  localparam int unsigned CmagW    = 2 * DataW;          // |cofactor|
  localparam int unsigned DetW     = 3 * DataW + 1;      // signed determinant
  localparam int unsigned DmagW    = 3 * DataW;          // |det|
  localparam int unsigned QuoW     = DataW + 1;          // quotient bits kept
  localparam int unsigned NumShift = 2 * FracW + 1;      // |c| * 2^(2F+1)
  localparam int unsigned NumW     = ((CmagW + NumShift) > DmagW) ?
                                     (CmagW + NumShift + 1) : (DmagW + 1);
  localparam int unsigned DenW     = DmagW + 1;          // 2 * |det|

  // Sideband that rides along with each quotient
  typedef struct packed {
    logic neg;
    logic sing;
  } side_t;

endpackage

// ===== src/mi3_divider.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage.
// Stage 0 checks for quotient overflow (>= 2^QuoW), stages 1..QuoW resolve bits.
module mi3_divider (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mi3_pkg::NumW-1:0]      num_i,
  input  logic [mi3_pkg::DenW-1:0]      den_i,
  input  mi3_pkg::side_t                side_i,
  output logic [mi3_pkg::QuoW-1:0]      quo_o,
  output logic                          sat_o,
  output mi3_pkg::side_t                side_o
);

  localparam int unsigned NStg = mi3_pkg::QuoW + 1;

  logic [mi3_pkg::DenW-1:0] rem_q  [NStg];
  logic [mi3_pkg::DenW-1:0] den_q  [NStg];
  logic [mi3_pkg::QuoW-1:0] low_q  [NStg];
  logic [mi3_pkg::QuoW-1:0] quo_q  [NStg];
  logic                     sat_q  [NStg];
  mi3_pkg::side_t           side_q [NStg];

  logic [mi3_pkg::NumW-mi3_pkg::QuoW-1:0] num_hi;

  assign num_hi = num_i[mi3_pkg::NumW-1:mi3_pkg::QuoW];

  // Overflow check and initial partial remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= mi3_pkg::DenW'(num_hi);
      den_q[0]  <= den_i;
      low_q[0]  <= num_i[mi3_pkg::QuoW-1:0];
      quo_q[0]  <= '0;
      sat_q[0]  <= (mi3_pkg::NumW'(num_hi) >= mi3_pkg::NumW'(den_i));
      side_q[0] <= side_i;
    end
  end

  // One compare-subtract per stage
  for (genvar k = 1; k < NStg; k++) begin : g_stg
    logic [mi3_pkg::DenW:0] trial;
    logic [mi3_pkg::DenW:0] diff;
    logic                   take;

    always_comb begin
      trial = {rem_q[k-1], low_q[k-1][mi3_pkg::QuoW-1]};
      diff  = trial - {1'b0, den_q[k-1]};
      take  = (trial >= {1'b0, den_q[k-1]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[mi3_pkg::DenW-1:0] : trial[mi3_pkg::DenW-1:0];
        den_q[k]  <= den_q[k-1];
        low_q[k]  <= {low_q[k-1][mi3_pkg::QuoW-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][mi3_pkg::QuoW-2:0], take};
        sat_q[k]  <= sat_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign quo_o  = quo_q[NStg-1];
  assign sat_o  = sat_q[NStg-1];
  assign side_o = side_q[NStg-1];

endmodule

// ===== src/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps

// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out. One matrix is
// accepted per clock cycle while the pipeline is not stalled. Each result
// passes through 43 registers in line: 8 front stages (input, products,
// cofactors, split determinant multiply, terms, determinant, magnitudes,
// numerator/denominator), a 34-stage one-bit-per-stage divider (one per entry)
// and the output register. Each entry is the exact quotient
// cofactor * 2^32 / det rounded to nearest (ties away from zero) and saturated.
// If |det| truncated to Q16.16 is below the threshold, or det is zero,
// m_axis_tuser is 1 and all entries are zero. Threshold reset value is 1.
// A stall on the output only holds the pipeline when its last stage is full.
module matrix_inverse_3x3 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: singular_threshold
  input  logic                              cfg_we_i,
  input  logic [mi3_pkg::ThrW-1:0]          cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each)
  input  logic [mi3_pkg::NumEnt*mi3_pkg::DataW-1:0] s_axis_tdata,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22 (32 bits each)
  output logic [mi3_pkg::NumEnt*mi3_pkg::DataW-1:0] m_axis_tdata,
  // singular
  output logic                              m_axis_tuser
);

  localparam int unsigned DW   = mi3_pkg::DataW;
  localparam int unsigned NE   = mi3_pkg::NumEnt;
  localparam int unsigned NPre = 8;
  localparam int unsigned NST  = NPre + mi3_pkg::QuoW + 1;

  // operand pairs of the 18 products: cofactor i = P[2i] - P[2i+1]
  localparam int unsigned ProdIdx [18][2] = '{
    '{4, 8}, '{5, 7}, '{2, 7}, '{1, 8}, '{1, 5}, '{2, 4},
    '{5, 6}, '{3, 8}, '{0, 8}, '{2, 6}, '{2, 3}, '{0, 5},
    '{3, 7}, '{4, 6}, '{1, 6}, '{0, 7}, '{0, 4}, '{1, 3}
  };

  // control
  logic [NST-1:0]           v_q;
  logic                     out_v_q;
  logic                     out_ld;
  logic                     en;
  logic [mi3_pkg::ThrW-1:0] thr_q;

  // payload stages
  logic signed [DW-1:0]              a_q      [NE];
  logic signed [mi3_pkg::ProdW-1:0]  prod_q   [18];
  logic signed [DW-1:0]              ar_b_q   [3];
  logic signed [mi3_pkg::CofW-1:0]   cof_c_q  [NE];
  logic signed [DW-1:0]              ar_c_q   [3];
  logic signed [mi3_pkg::CofW-1:0]   lo_q     [3];
  logic signed [mi3_pkg::CofW-1:0]   hi_q     [3];
  logic signed [mi3_pkg::CofW-1:0]   cof_d_q  [NE];
  logic signed [mi3_pkg::DetW-1:0]   t_q      [3];
  logic signed [mi3_pkg::CofW-1:0]   cof_e_q  [NE];
  logic signed [mi3_pkg::DetW-1:0]   det_q;
  logic signed [mi3_pkg::CofW-1:0]   cof_f_q  [NE];
  logic [mi3_pkg::DmagW-1:0]         dmag_q;
  logic                              dneg_q;
  logic [mi3_pkg::CmagW-1:0]         cmag_q   [NE];
  logic                              cneg_q   [NE];
  logic [mi3_pkg::NumW-1:0]          num_q    [NE];
  logic [mi3_pkg::DenW-1:0]          den_q;
  mi3_pkg::side_t                    side_h_q [NE];

  logic [mi3_pkg::QuoW-1:0]          quo      [NE];
  logic                              sat      [NE];
  mi3_pkg::side_t                    side_o   [NE];

  logic [NE*DW-1:0]                  tdata_d;
  logic                              tuser_d;
  logic [NE*DW-1:0]                  tdata_q;
  logic                              tuser_q;

  // flow control: hold only when the last stage cannot drain
  assign out_ld        = !out_v_q || m_axis_tready;
  assign en            = !v_q[NST-1] || out_ld;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
      thr_q   <= mi3_pkg::ThrW'(1);
    end else begin
      if (en) begin
        v_q <= {v_q[NST-2:0], s_axis_tvalid};
      end
      if (out_ld) begin
        out_v_q <= v_q[NST-1];
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // stages A-H: input, products, cofactors, split multiply, terms, det, magnitudes, num/den
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NE; i++) begin
        a_q[i] <= s_axis_tdata[i*DW +: DW];
      end
      for (int j = 0; j < 18; j++) begin
        prod_q[j] <= a_q[ProdIdx[j][0]] * a_q[ProdIdx[j][1]];
      end
      for (int j = 0; j < 3; j++) begin
        ar_b_q[j] <= a_q[j];
        ar_c_q[j] <= ar_b_q[j];
      end
      for (int i = 0; i < NE; i++) begin
        cof_c_q[i] <= mi3_pkg::CofW'(prod_q[2*i]) - mi3_pkg::CofW'(prod_q[2*i+1]);
        cof_d_q[i] <= cof_c_q[i];
        cof_e_q[i] <= cof_d_q[i];
        cof_f_q[i] <= cof_e_q[i];
      end
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= ar_c_q[j] * $signed({1'b0, cof_c_q[3*j][DW-1:0]});
        hi_q[j] <= ar_c_q[j] * $signed(cof_c_q[3*j][mi3_pkg::CofW-1:DW]);
        t_q[j]  <= (mi3_pkg::DetW'(hi_q[j]) <<< DW) + mi3_pkg::DetW'(lo_q[j]);
      end
      det_q  <= t_q[0] + t_q[1] + t_q[2];
      dneg_q <= det_q[mi3_pkg::DetW-1];
      dmag_q <= det_q[mi3_pkg::DetW-1] ? mi3_pkg::DmagW'(-det_q) : mi3_pkg::DmagW'(det_q);
      for (int i = 0; i < NE; i++) begin
        cneg_q[i] <= cof_f_q[i][mi3_pkg::CofW-1];
        cmag_q[i] <= cof_f_q[i][mi3_pkg::CofW-1] ? mi3_pkg::CmagW'(-cof_f_q[i])
                                                 : mi3_pkg::CmagW'(cof_f_q[i]);
      end
      // rounding term |det| folded into the numerator
      den_q <= {dmag_q, 1'b0};
      for (int i = 0; i < NE; i++) begin
        num_q[i] <= (mi3_pkg::NumW'(cmag_q[i]) << mi3_pkg::NumShift)
                    + mi3_pkg::NumW'(dmag_q);
        side_h_q[i].neg  <= cneg_q[i] ^ dneg_q;
        side_h_q[i].sing <= (dmag_q == '0) ||
                            (dmag_q < (mi3_pkg::DmagW'(thr_q) << (2 * mi3_pkg::FracW)));
      end
    end
  end

  // one divider per entry
  for (genvar i = 0; i < NE; i++) begin : g_div
    mi3_divider u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num_q[i]),
      .den_i  (den_q),
      .side_i (side_h_q[i]),
      .quo_o  (quo[i]),
      .sat_o  (sat[i]),
      .side_o (side_o[i])
    );
  end

  // saturate, apply sign, zero when singular
  always_comb begin
    logic [mi3_pkg::QuoW-1:0] lim;
    logic [mi3_pkg::QuoW-1:0] mag;
    logic [mi3_pkg::QuoW-1:0] val;
    tdata_d = '0;
    tuser_d = side_o[0].sing;
    for (int i = 0; i < NE; i++) begin
      lim = side_o[i].neg ? (mi3_pkg::QuoW'(1) << (DW - 1))
                          : ((mi3_pkg::QuoW'(1) << (DW - 1)) - mi3_pkg::QuoW'(1));
      mag = (sat[i] || (quo[i] > lim)) ? lim : quo[i];
      val = side_o[i].neg ? (~mag + mi3_pkg::QuoW'(1)) : mag;
      tdata_d[i*DW +: DW] = side_o[i].sing ? '0 : val[DW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_ld && v_q[NST-1]) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  // assertions
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("singular result with nonzero entries");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> out_v_q)
    else $error("pending result lost");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted matrix not tracked in pipeline");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> (v_q == $past(v_q)))
    else $error("pipeline moved while stalled");

endmodule

// ===== tb/sv/matrix_inverse_3x3_test.sv =====
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;

  localparam int unsigned MatW     = mi3_pkg::NumEnt * mi3_pkg::DataW;
  localparam int unsigned Latency  = 42;
  localparam int unsigned DrainWait = Latency + 20;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned LongHold = 300;

  typedef logic signed [199:0] wide_t;
  typedef logic [199:0] uwide_t;

  typedef struct packed {
    logic [MatW-1:0] entries;
    logic            singular;
  } inverse_t;

  // Entry generator kinds
  typedef enum int {
    ENT_FULL, ENT_NEAR_ONE, ENT_TINY, ENT_SPARSE, ENT_EXTREME
  } entry_kind_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [mi3_pkg::ThrW-1:0]   cfg_wdata_i;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  // a00 .. a22, 32 bits each, a00 lowest
  logic [MatW-1:0]            s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  // inv00 .. inv22, 32 bits each, inv00 lowest
  logic [MatW-1:0]            m_axis_tdata;
  // singular
  logic                       m_axis_tuser;

  matrix_inverse_3x3 i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  inverse_t                 pending_inverses[$];
  logic [mi3_pkg::ThrW-1:0] model_thr;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              hold_seq;
  int              errors;
  int              mismatches;
  int              sent_count;
  int              recv_count;
  int              singular_count;
  int              idle_cycles;

  // Clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predicted inverse of one matrix at the current threshold
  function automatic inverse_t predict_inverse(logic [MatW-1:0] m,
                                               logic [mi3_pkg::ThrW-1:0] thr);
    wide_t    a[9];
    wide_t    c[9];
    wide_t    det;
    uwide_t   dmag;
    uwide_t   cmag;
    uwide_t   num;
    uwide_t   den;
    uwide_t   quo;
    uwide_t   lim;
    uwide_t   thr_full;
    logic     neg;
    inverse_t r;
    for (int i = 0; i < 9; i++) begin
      a[i] = wide_t'($signed(m[32*i +: 32]));
    end
    c[0] = a[4] * a[8] - a[5] * a[7];
    c[1] = a[2] * a[7] - a[1] * a[8];
    c[2] = a[1] * a[5] - a[2] * a[4];
    c[3] = a[5] * a[6] - a[3] * a[8];
    c[4] = a[0] * a[8] - a[2] * a[6];
    c[5] = a[2] * a[3] - a[0] * a[5];
    c[6] = a[3] * a[7] - a[4] * a[6];
    c[7] = a[1] * a[6] - a[0] * a[7];
    c[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
    dmag = (det < 0) ? uwide_t'(-det) : uwide_t'(det);
    thr_full = uwide_t'(thr) << (2 * mi3_pkg::FracW);
    r.singular = (det == 0) || (dmag < thr_full);
    r.entries = '0;
    if (!r.singular) begin
      for (int i = 0; i < 9; i++) begin
        cmag = (c[i] < 0) ? uwide_t'(-c[i]) : uwide_t'(c[i]);
        neg = (c[i] < 0) != (det < 0);
        // round to nearest, ties away from zero
        num = (cmag << (2 * mi3_pkg::FracW + 1)) + dmag;
        den = dmag << 1;
        quo = num / den;
        lim = neg ? uwide_t'(64'h8000_0000) : uwide_t'(64'h7FFF_FFFF);
        if (quo > lim) quo = lim;
        if (neg) quo = -quo;
        r.entries[32*i +: 32] = quo[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] random_entry(entry_kind_e kind);
    logic [31:0] v;
    case (kind)
      ENT_FULL: begin
        v = $urandom;
      end
      ENT_NEAR_ONE: begin
        v = $urandom_range(32'h0004_0000);
        v = v - 32'h0002_0000;
      end
      ENT_TINY: begin
        v = $urandom_range(64) - 32;
      end
      ENT_SPARSE: begin
        v = ($urandom_range(2) == 0) ? 32'h0 : ($urandom & 32'h000F_FFFF) - 32'h0008_0000;
      end
      default: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [MatW-1:0] random_matrix();
    logic [MatW-1:0] m;
    entry_kind_e     kind;
    int              pick;
    pick = $urandom_range(99);
    if (pick < 35) kind = ENT_NEAR_ONE;
    else if (pick < 55) kind = ENT_FULL;
    else if (pick < 70) kind = ENT_SPARSE;
    else if (pick < 85) kind = ENT_TINY;
    else kind = ENT_EXTREME;
    for (int i = 0; i < 9; i++) begin
      m[32*i +: 32] = ($urandom_range(9) == 0) ? random_entry(ENT_FULL) : random_entry(kind);
    end
    // rank-deficient: repeat a row
    if ($urandom_range(9) == 0) begin
      m[96*($urandom_range(2)) +: 96] = m[96*($urandom_range(2)) +: 96];
    end
    return m;
  endfunction

  function automatic logic [MatW-1:0] diag_matrix(logic [31:0] d0, logic [31:0] d1,
                                                  logic [31:0] d2);
    logic [MatW-1:0] m;
    m = '0;
    m[0 +: 32] = d0;
    m[128 +: 32] = d1;
    m[256 +: 32] = d2;
    return m;
  endfunction

  // Send one matrix; tvalid stays high until the next send or an idle pause
  task automatic send_matrix(logic [MatW-1:0] m);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_inverses.push_back(predict_inverse(m, model_thr));
    sent_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [mi3_pkg::ThrW-1:0] thr);
    wait_drained();
    cfg_wdata_i <= thr;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_thr = thr;
  endtask

  task automatic test_directed();
    logic [MatW-1:0] m;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // identity, negated identity, zero matrix
    send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag_matrix(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
    send_matrix('0);
    // determinant exactly at and just below the reset threshold
    send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h1));
    send_matrix(diag_matrix(32'h0001_0000, 32'h0000_FFFF, 32'h1));
    // all entries at the extremes
    send_matrix({mi3_pkg::NumEnt{32'h7FFF_FFFF}});
    send_matrix({mi3_pkg::NumEnt{32'h8000_0000}});
    send_matrix({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000});
    send_matrix(diag_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_matrix(diag_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // row swap gives a negative determinant
    m = '0;
    m[32 +: 32] = 32'h0002_0000;
    m[96 +: 32] = 32'h0000_8000;
    m[256 +: 32] = 32'h0003_0000;
    send_matrix(m);
    // large inverse entries that stay within range
    send_matrix(diag_matrix(32'h0000_0100, 32'h0000_0100, 32'h0001_0000));
    send_matrix(diag_matrix(32'hFFFF_FF00, 32'h0000_0100, 32'h0001_0000));
    // dense well-conditioned matrix
    send_matrix({32'h0002_0000, 32'h0000_4000, 32'hFFFF_8000, 32'h0000_C000,
                 32'h0003_0000, 32'h0000_2000, 32'hFFFE_0000, 32'h0000_1000,
                 32'h0001_8000});
    // zero threshold: only a zero determinant is singular
    write_threshold('0);
    send_matrix(diag_matrix(32'h1, 32'h1, 32'h1));
    send_matrix(diag_matrix(32'hFFFF_FFFF, 32'h1, 32'h1));
    send_matrix('0);
    send_matrix({mi3_pkg::NumEnt{32'h0001_0000}});
    // largest threshold
    write_threshold({mi3_pkg::ThrW{1'b1}});
    send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    write_threshold(31'd1);
  endtask

  task automatic test_random(int n, int tx_pct, int rx_pct, logic [mi3_pkg::ThrW-1:0] thr);
    write_threshold(thr);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      send_matrix(random_matrix());
    end
  endtask

  // Receiver holds off while the sender keeps going, so the pipeline backs up
  task automatic test_backpressure();
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 100; i++) begin
      send_matrix(random_matrix());
    end
    // sender pause until everything has come back
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_matrix(random_matrix());
    end
  endtask

  // Output ready, with an occasional long hold-off
  always @(posedge clk_i) begin
    static int hold_left = 0;
    static int seen_seq = 0;
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    inverse_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      recv_count++;
      if (pending_inverses.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no matrix outstanding");
      end else begin
        want = pending_inverses.pop_front();
        if (want.singular) singular_count++;
        if (want.entries !== m_axis_tdata || want.singular !== m_axis_tuser) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            for (int i = 0; i < 9; i++) begin
              if (want.entries[32*i +: 32] !== m_axis_tdata[32*i +: 32]) begin
                $display("ERROR: result %0d inv%0d%0d expected %h got %h", recv_count,
                         i / 3, i % 3, want.entries[32*i +: 32], m_axis_tdata[32*i +: 32]);
              end
            end
            if (want.singular !== m_axis_tuser) begin
              $display("ERROR: result %0d singular expected %b got %b", recv_count,
                       want.singular, m_axis_tuser);
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    model_thr   = 31'd1;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_seq    = 0;
    errors      = 0;
    mismatches  = 0;
    sent_count  = 0;
    recv_count  = 0;
    singular_count = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(560, 33, 54, 31'd1);
    test_random(560, 54, 33, mi3_pkg::ThrW'($urandom_range(32'h0001_0000)));
    test_random(560, 0, 0, mi3_pkg::ThrW'($urandom_range(16)));
    test_random(30, 0, 0, {mi3_pkg::ThrW{1'b1}});
    test_backpressure();
    wait_drained();

    if (pending_inverses.size() != 0) errors++;
    $display("Covered %0d matrices, %0d results (%0d singular), under idle mixes,",
             sent_count, recv_count, singular_count);
    $display("threshold changes from zero to full scale and a long output stall.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== matrix_inverse_3x3.f =====
src/mi3_pkg.sv
src/mi3_divider.sv
src/matrix_inverse_3x3.sv
tb/sv/matrix_inverse_3x3_test.sv
